// ===== hw/rtl/cou_pkg.sv =====
// Shared request codes, constants and pipeline stage types of the color operation unit.
package cou_pkg;

    localparam logic [2:0] REQ_BLEND  = 3'd0;
    localparam logic [2:0] REQ_INVERT = 3'd1;
    localparam logic [2:0] REQ_GRAY   = 3'd2;
    localparam logic [2:0] REQ_BRIGHT = 3'd3;
    localparam logic [2:0] REQ_HSV    = 3'd4;

    localparam logic [4:0] CMAX       = 5'd31;
    localparam logic [7:0] FULL_RATIO = 8'd255;
    localparam logic [12:0] MIX_ROUND = 13'd128;
    localparam logic [7:0] LUM_RED    = 8'd77;
    localparam logic [7:0] LUM_GREEN  = 8'd150;
    localparam logic [7:0] LUM_BLUE   = 8'd29;
    localparam logic [7:0] SECTOR_LEN = 8'd43;

    typedef struct packed {
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [2:0] req_type;
        t_rgb       a;
        t_rgb       b;
        logic [7:0] mix_ratio;
        logic [7:0] bright_delta;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } t_req;

    // after stage 1: simple ops done, hue split into sector and fraction
    typedef struct packed {
        logic [2:0] req_type;
        t_rgb       simple;
        logic       gray;
        logic [2:0] sector;
        logic [7:0] frac;
        logic [7:0] sat;
        logic [7:0] val;
    } t_s1;

    // after stage 2: saturation terms and p component ready
    typedef struct packed {
        logic [2:0] req_type;
        t_rgb       simple;
        logic       gray;
        logic [2:0] sector;
        logic [7:0] val;
        logic [7:0] k_q;
        logic [7:0] k_t;
        logic [4:0] p;
    } t_s2;

endpackage

// ===== hw/rtl/cou_front.sv =====
// Stage 1: blend, invert, grayscale and brightness, plus hue sector split.
module cou_front
    import cou_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_vld,
    input  t_req i_req,
    output logic o_vld,
    output t_s1  o_data
);

    logic       r_vld;
    t_s1        r_data;
    t_s1        n_data;

    function automatic logic [4:0] mix5(input logic [4:0] x, input logic [4:0] y,
                                        input logic [7:0] w);
        logic [12:0] acc;
        acc = 13'(x) * 13'(FULL_RATIO - w) + 13'(y) * 13'(w) + MIX_ROUND;
        return acc[12:8];
    endfunction

    function automatic logic [4:0] add_sat(input logic [4:0] x, input logic [4:0] m);
        logic [5:0] sum;
        sum = 6'(x) + 6'(m);
        return (sum > 6'(CMAX)) ? CMAX : sum[4:0];
    endfunction

    function automatic logic [4:0] sub_sat(input logic [4:0] x, input logic [4:0] m);
        return (x > m) ? (x - m) : 5'd0;
    endfunction

    logic [12:0] lum;
    logic [7:0]  mag;
    logic [4:0]  mag5;
    logic [7:0]  base;
    logic [5:0]  diff;
    t_rgb        simple;

    always_comb begin
        lum = 13'(LUM_RED) * 13'(i_req.a.red) + 13'(LUM_GREEN) * 13'(i_req.a.green)
            + 13'(LUM_BLUE) * 13'(i_req.a.blue);
        mag  = i_req.bright_delta[7] ? (8'd0 - i_req.bright_delta) : i_req.bright_delta;
        mag5 = (mag > 8'(CMAX)) ? CMAX : mag[4:0];

        simple = i_req.a;
        unique case (i_req.req_type)
            REQ_BLEND: begin
                if (i_req.mix_ratio == 8'd0) begin
                    simple = i_req.a;
                end else if (i_req.mix_ratio == FULL_RATIO) begin
                    simple = i_req.b;
                end else begin
                    simple.red   = mix5(i_req.a.red, i_req.b.red, i_req.mix_ratio);
                    simple.green = mix5(i_req.a.green, i_req.b.green, i_req.mix_ratio);
                    simple.blue  = mix5(i_req.a.blue, i_req.b.blue, i_req.mix_ratio);
                end
            end
            REQ_INVERT: begin
                simple.red   = CMAX - i_req.a.red;
                simple.green = CMAX - i_req.a.green;
                simple.blue  = CMAX - i_req.a.blue;
            end
            REQ_GRAY: begin
                simple.red   = lum[12:8];
                simple.green = lum[12:8];
                simple.blue  = lum[12:8];
            end
            REQ_BRIGHT: begin
                if (i_req.bright_delta[7]) begin
                    simple.red   = sub_sat(i_req.a.red, mag5);
                    simple.green = sub_sat(i_req.a.green, mag5);
                    simple.blue  = sub_sat(i_req.a.blue, mag5);
                end else begin
                    simple.red   = add_sat(i_req.a.red, mag5);
                    simple.green = add_sat(i_req.a.green, mag5);
                    simple.blue  = add_sat(i_req.a.blue, mag5);
                end
            end
            default: simple = i_req.a;
        endcase

        priority if (i_req.hue < SECTOR_LEN) begin
            n_data.sector = 3'd0;
        end else if (i_req.hue < 8'(2 * SECTOR_LEN)) begin
            n_data.sector = 3'd1;
        end else if (i_req.hue < 8'(3 * SECTOR_LEN)) begin
            n_data.sector = 3'd2;
        end else if (i_req.hue < 8'(4 * SECTOR_LEN)) begin
            n_data.sector = 3'd3;
        end else if (i_req.hue < 8'(5 * SECTOR_LEN)) begin
            n_data.sector = 3'd4;
        end else begin
            n_data.sector = 3'd5;
        end
        base = 8'(SECTOR_LEN * n_data.sector);
        diff = 6'(i_req.hue - base);

        n_data.req_type = i_req.req_type;
        n_data.simple   = simple;
        n_data.gray     = (i_req.sat == 8'd0);
        n_data.frac     = 8'(diff) * 8'd6;
        n_data.sat      = i_req.sat;
        n_data.val      = i_req.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// ===== hw/rtl/cou_hsv_scale.sv =====
// Stage 2: saturation products and the p component of the HSV conversion.
module cou_hsv_scale
    import cou_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_vld,
    input  t_s1  i_data,
    output logic o_vld,
    output t_s2  o_data
);

    logic        r_vld;
    t_s2         r_data;
    t_s2         n_data;
    logic [15:0] prod_q;
    logic [15:0] prod_t;
    logic [15:0] prod_p;

    always_comb begin
        prod_q = 16'(i_data.sat) * 16'(i_data.frac);
        prod_t = 16'(i_data.sat) * 16'(FULL_RATIO - i_data.frac);
        prod_p = 16'(i_data.val) * 16'(FULL_RATIO - i_data.sat);

        n_data.req_type = i_data.req_type;
        n_data.simple   = i_data.simple;
        n_data.gray     = i_data.gray;
        n_data.sector   = i_data.sector;
        n_data.val      = i_data.val;
        n_data.k_q      = prod_q[15:8];
        n_data.k_t      = prod_t[15:8];
        // scale to 8 bits, then drop to 5
        n_data.p        = prod_p[15:11];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// ===== hw/rtl/cou_place.sv =====
// Stage 3: q and t components, sector placement and the output register.
module cou_place
    import cou_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_vld,
    input  t_s2  i_data,
    output logic o_vld,
    output t_rgb o_rgb
);

    logic        r_vld;
    t_rgb        r_rgb;
    t_rgb        n_rgb;
    logic [15:0] prod_q;
    logic [15:0] prod_t;
    logic [4:0]  q;
    logic [4:0]  t;
    logic [4:0]  v;
    logic [4:0]  p;

    always_comb begin
        prod_q = 16'(i_data.val) * 16'(FULL_RATIO - i_data.k_q);
        prod_t = 16'(i_data.val) * 16'(FULL_RATIO - i_data.k_t);
        q = prod_q[15:11];
        t = prod_t[15:11];
        v = i_data.val[7:3];
        p = i_data.p;

        if (i_data.req_type != REQ_HSV) begin
            n_rgb = i_data.simple;
        end else if (i_data.gray) begin
            n_rgb = '{red: v, green: v, blue: v};
        end else begin
            unique case (i_data.sector)
                3'd0:    n_rgb = '{red: v, green: t, blue: p};
                3'd1:    n_rgb = '{red: q, green: v, blue: p};
                3'd2:    n_rgb = '{red: p, green: v, blue: t};
                3'd3:    n_rgb = '{red: p, green: q, blue: v};
                3'd4:    n_rgb = '{red: t, green: p, blue: v};
                default: n_rgb = '{red: v, green: p, blue: q};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_vld = r_vld;
    assign o_rgb = r_rgb;

endmodule

// ===== hw/rtl/color_op_unit.sv =====
// Each accepted request passes through the front, hsv_scale and place stage registers.
// Throughput: one request per cycle while not stalled; each of the three stages advances when
// it is empty or the stage after it moves, so bubbles fill behind a stall.
// The longest path per stage is one 8x8 multiply or the 5x8 blend sums.
// Reset (synchronous, active low) clears all stage valid bits.
module color_op_unit
    import cou_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_req_type,
    input  logic [4:0] i_a_red,
    input  logic [4:0] i_a_green,
    input  logic [4:0] i_a_blue,
    input  logic [4:0] i_b_red,
    input  logic [4:0] i_b_green,
    input  logic [4:0] i_b_blue,
    input  logic [7:0] i_mix_ratio,
    input  logic signed [7:0] i_bright_delta,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_sat,
    input  logic [7:0] i_val,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [4:0] o_out_red,
    output logic [4:0] o_out_green,
    output logic [4:0] o_out_blue
);

    t_req req;
    t_s1  s1_data;
    t_s2  s2_data;
    t_rgb s3_rgb;
    logic s1_vld;
    logic s2_vld;
    logic s3_vld;
    logic adv1;
    logic adv2;
    logic adv3;

    always_comb begin
        req.req_type     = i_req_type;
        req.a            = '{red: i_a_red, green: i_a_green, blue: i_a_blue};
        req.b            = '{red: i_b_red, green: i_b_green, blue: i_b_blue};
        req.mix_ratio    = i_mix_ratio;
        req.bright_delta = i_bright_delta;
        req.hue          = i_hue;
        req.sat          = i_sat;
        req.val          = i_val;
    end

    // a stage moves when it is empty or its successor moves
    assign adv3    = !s3_vld || !i_stall;
    assign adv2    = !s2_vld || adv3;
    assign adv1    = !s1_vld || adv2;
    assign o_stall = !adv1;

    cou_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv1),
        .i_vld   (i_valid),
        .i_req   (req),
        .o_vld   (s1_vld),
        .o_data  (s1_data)
    );

    cou_hsv_scale u_hsv_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv2),
        .i_vld   (s1_vld),
        .i_data  (s1_data),
        .o_vld   (s2_vld),
        .o_data  (s2_data)
    );

    cou_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv3),
        .i_vld   (s2_vld),
        .i_data  (s2_data),
        .o_vld   (s3_vld),
        .o_rgb   (s3_rgb)
    );

    assign o_valid     = s3_vld;
    assign o_out_red   = s3_rgb.red;
    assign o_out_green = s3_rgb.green;
    assign o_out_blue  = s3_rgb.blue;

endmodule

// ===== hw/rtl/cou_check.sv =====
// Port-level checker for the color operation unit and its bind to the top level.
module cou_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [4:0] o_out_red,
    input logic [4:0] o_out_green,
    input logic [4:0] o_out_blue
);

    // an empty output stage never backs up the input
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage is empty");

    // a request accepted while the output runs free of stalls reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("request did not reach the output in three cycles");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_red)
            && $stable(o_out_green) && $stable(o_out_blue))
        else $error("stalled result changed");

endmodule

bind color_op_unit cou_check u_cou_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
